[design/separable_gaussian_blur_argb_core_assert.svh]
// Assertion macros used by the blur core checker.
`ifndef SEPARABLE_GAUSSIAN_BLUR_ARGB_CORE_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_ARGB_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGB_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("blur core check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGB_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("blur core check failed");

`endif

[design/sgb_pkg.sv]
// Package with the shared constants of the separable blur core.
package sgb_pkg;

  localparam int TAPS = 17;
  localparam int HALF = 8;
  localparam int BANK_W = 5;
  localparam int PIX_W = 32;
  localparam int CH_W = 8;
  localparam int CH_N = 4;
  localparam int DIM_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH = 11'd800;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  localparam int W_W = 7;
  localparam logic [W_W-1:0] WEIGHTS [TAPS] = '{
    7'd9, 7'd15, 7'd24, 7'd34, 7'd46, 7'd59, 7'd70, 7'd77, 7'd80,
    7'd77, 7'd70, 7'd59, 7'd46, 7'd34, 7'd24, 7'd15, 7'd9
  };

  localparam int PROD_W = CH_W + W_W;
  localparam int ACC_W = 18;

  // Division by the kernel sum 748 is exact as a multiply by ceil(2^32/748)
  // followed by a right shift of 32 for any sum below 2^18.
  localparam int RECIP_W = 23;
  localparam logic [RECIP_W-1:0] RECIP = 23'd5741935;
  localparam int RECIP_SHIFT = 32;

endpackage

[design/sgb_lane.sv]
// One 8-bit channel of the 17-tap kernel: weighted sum and division by 748.
module sgb_lane import sgb_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [TAPS-1:0][CH_W-1:0]  tap,
  input  logic [TAPS-1:0]            mask,
  output logic [CH_W-1:0]            quot
);

  localparam int GROUP = 5;
  localparam int NGROUP = (TAPS + GROUP - 1) / GROUP;
  localparam int MUL_W = ACC_W + RECIP_W;

  logic [ACC_W-1:0] psum_c [NGROUP];
  logic [ACC_W-1:0] psum [NGROUP];
  logic [ACC_W-1:0] acc_c;
  logic [ACC_W-1:0] acc;
  logic [MUL_W-1:0] mul;
  logic [RECIP_W-1:0] rc;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      psum_c[g] = '0;
    end
    for (int k = 0; k < TAPS; k++) begin
      if (mask[k]) begin
        psum_c[k / GROUP] = psum_c[k / GROUP]
                          + ACC_W'(PROD_W'(tap[k]) * PROD_W'(WEIGHTS[k]));
      end
    end
  end

  always_comb begin
    acc_c = '0;
    for (int g = 0; g < NGROUP; g++) begin
      acc_c = acc_c + psum[g];
    end
  end

  assign rc = RECIP;
  assign mul = MUL_W'(acc) * MUL_W'(rc);

  always_ff @(posedge clk) begin
    if (en) begin
      psum <= psum_c;
      acc <= acc_c;
      quot <= mul[RECIP_SHIFT +: CH_W];
    end
  end

endmodule

[design/sgb_filter.sv]
// Four channel lanes side by side, merged back into one packed pixel.
module sgb_filter import sgb_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic [TAPS-1:0][PIX_W-1:0]  taps,
  input  logic [TAPS-1:0]             mask,
  output logic [PIX_W-1:0]            result
);

  logic [CH_N-1:0][CH_W-1:0] lane_q;

  for (genvar c = 0; c < CH_N; c++) begin : g_lane
    logic [TAPS-1:0][CH_W-1:0] ch_tap;

    always_comb begin
      for (int k = 0; k < TAPS; k++) begin
        ch_tap[k] = taps[k][c*CH_W +: CH_W];
      end
    end

    sgb_lane u_lane (
      .clk  (clk),
      .en   (en),
      .tap  (ch_tap),
      .mask (mask),
      .quot (lane_q[c])
    );
  end

  assign result = lane_q;

endmodule

[design/sgb_row_store.sv]
// Seventeen row banks of horizontal results, one bank per row modulo 17.
module sgb_row_store import sgb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             we,
  input  logic [BANK_W-1:0]                wbank,
  input  logic [$clog2(MAX_WIDTH)-1:0]     waddr,
  input  logic [PIX_W-1:0]                 wdata,
  input  logic [$clog2(MAX_WIDTH)-1:0]     raddr,
  output logic [TAPS-1:0][PIX_W-1:0]       rdata
);

  for (genvar b = 0; b < TAPS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic hit;

    assign hit = we && (wbank == BANK_W'(b));

    always_ff @(posedge clk) begin
      if (en) begin
        if (hit) begin
          mem[waddr] <= wdata;
        end
        if (hit && waddr == raddr) begin
          rdata[b] <= wdata;
        end else begin
          rdata[b] <= mem[raddr];
        end
      end
    end
  end

endmodule

[design/separable_gaussian_blur_argb_core.sv]
// Top level of the separable 17-tap blur core for packed four-channel pixels.
// Pixels enter on in_valid/in_ready in raster order, one transfer per clock,
// frame_width*frame_height pixels followed by 8*frame_width+8 padding items.
// The blurred pixel for raster position p leaves on out_valid/out_ready as
// the result of input item p+8*frame_width+8; frame_end marks the last pixel
// of the frame. Throughput is one item per cycle when not stalled, set by
// the four channel lanes of each filter and the single write and read per
// cycle of each row bank.
// The configuration channel is always ready; write frame_width (index 0) and
// frame_height (index 1) only while the core is idle. Dimensions of 0 act
// as 1, larger than the maximum act as the maximum.
// Reset clears the item count, the pipeline valids and the dimensions
// (800 by 480); the row buffers need no clearing.
// When the receiver holds out_ready low with a result pending, the whole
// pipeline freezes and in_ready drops until that result is taken.
module separable_gaussian_blur_argb_core import sgb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WD = $clog2(MAX_WIDTH + 1);
  localparam int HD = $clog2(MAX_HEIGHT + 1);
  localparam int QW = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF * MAX_WIDTH + HALF + 1);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [WD-1:0] w_c;
  logic [HD-1:0] h_c;
  logic [QW-1:0] npix;
  logic [QW-1:0] lag;
  logic [QW-1:0] total;

  logic [QW-1:0] q;
  logic [QW-1:0] q_e;
  logic wrap;
  logic accept;
  logic en;
  logic hact;
  logic vact;
  logic frame_done;

  logic [CW-1:0] hcol;
  logic [BANK_W-1:0] hbank;
  logic [CW-1:0] vcol;
  logic [RW-1:0] vrow;
  logic [BANK_W-1:0] vbank;
  logic [CW-1:0] hcol_e;
  logic [BANK_W-1:0] hbank_e;
  logic [CW-1:0] vcol_e;
  logic [RW-1:0] vrow_e;
  logic [BANK_W-1:0] vbank_e;
  logic h_last;
  logic v_lastcol;
  logic v_lastrow;

  logic [TAPS-1:0] h_mask_c;
  logic [TAPS-1:0] v_mask_c;

  logic [TAPS-1:0][PIX_W-1:0] win;
  logic [TAPS-1:0][PIX_W-1:0] htaps;

  logic h1_v;
  logic [CW-1:0] h1_col;
  logic [BANK_W-1:0] h1_bank;
  logic [TAPS-1:0] h1_mask;
  logic v1_v;
  logic [CW-1:0] v1_col;
  logic [BANK_W-1:0] v1_bank;
  logic [TAPS-1:0] v1_mask;
  logic v1_end;

  logic hd_v [3];
  logic [CW-1:0] hd_col [3];
  logic [BANK_W-1:0] hd_bank [3];
  logic vd_v [4];
  logic [CW-1:0] vd_col [3];
  logic [BANK_W-1:0] vd_bank [4];
  logic [TAPS-1:0] vd_mask [4];
  logic vd_end [4];

  logic [PIX_W-1:0] hres;
  logic [TAPS-1:0][PIX_W-1:0] rdata;
  logic [TAPS-1:0][PIX_W-1:0] rot;
  logic [TAPS-1:0][PIX_W-1:0] vtaps;
  logic [TAPS-1:0] v6_mask;
  logic v6_v;
  logic v6_end;
  logic ve_v [3];
  logic ve_end [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_c = WD'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_c = WD'(MAX_WIDTH);
    end else begin
      w_c = WD'(frame_width);
    end
    if (frame_height == '0) begin
      h_c = HD'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_c = HD'(MAX_HEIGHT);
    end else begin
      h_c = HD'(frame_height);
    end
  end

  assign npix = QW'(w_c) * QW'(h_c);
  assign lag = QW'(w_c) * QW'(HALF) + QW'(HALF);
  assign total = npix + lag;

  assign en = !ve_v[2] || out_ready;
  assign in_ready = en;
  assign accept = in_valid && in_ready;

  assign wrap = q >= total;
  assign q_e = wrap ? '0 : q;
  assign hcol_e = wrap ? '0 : hcol;
  assign hbank_e = wrap ? '0 : hbank;
  assign vcol_e = wrap ? '0 : vcol;
  assign vrow_e = wrap ? '0 : vrow;
  assign vbank_e = wrap ? '0 : vbank;

  assign hact = (q_e >= QW'(HALF)) && (q_e < npix + QW'(HALF));
  assign vact = q_e >= lag;
  assign frame_done = (q_e + QW'(1)) >= total;
  assign h_last = WD'(hcol_e) == w_c - WD'(1);
  assign v_lastcol = WD'(vcol_e) == w_c - WD'(1);
  assign v_lastrow = HD'(vrow_e) == h_c - HD'(1);

  always_comb begin
    logic [WD:0] hs;
    logic [HD:0] vs;
    for (int k = 0; k < TAPS; k++) begin
      hs = (WD+1)'(hcol_e) + (WD+1)'(k);
      h_mask_c[k] = (hs >= (WD+1)'(HALF)) && (hs - (WD+1)'(HALF) < (WD+1)'(w_c));
      vs = (HD+1)'(vrow_e) + (HD+1)'(k);
      v_mask_c[k] = (vs >= (HD+1)'(HALF)) && (vs - (HD+1)'(HALF) < (HD+1)'(h_c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
      hcol <= '0;
      hbank <= '0;
      vcol <= '0;
      vrow <= '0;
      vbank <= '0;
    end else if (accept) begin
      if (frame_done) begin
        q <= '0;
        hcol <= '0;
        hbank <= '0;
        vcol <= '0;
        vrow <= '0;
        vbank <= '0;
      end else begin
        q <= q_e + QW'(1);
        hcol <= hcol_e;
        hbank <= hbank_e;
        vcol <= vcol_e;
        vrow <= vrow_e;
        vbank <= vbank_e;
        if (hact) begin
          if (h_last) begin
            hcol <= '0;
            hbank <= (hbank_e == BANK_W'(TAPS - 1)) ? '0 : hbank_e + BANK_W'(1);
          end else begin
            hcol <= hcol_e + CW'(1);
          end
        end
        if (vact) begin
          if (v_lastcol) begin
            vcol <= '0;
            vrow <= vrow_e + RW'(1);
            vbank <= (vbank_e == BANK_W'(TAPS - 1)) ? '0 : vbank_e + BANK_W'(1);
          end else begin
            vcol <= vcol_e + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= (q_e < npix) ? pixel_in : '0;
      for (int i = 1; i < TAPS; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_v <= 1'b0;
      v1_v <= 1'b0;
      v6_v <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hd_v[i] <= 1'b0;
        ve_v[i] <= 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
        vd_v[i] <= 1'b0;
      end
    end else if (en) begin
      h1_v <= accept && hact;
      v1_v <= accept && vact;
      hd_v[0] <= h1_v;
      vd_v[0] <= v1_v;
      for (int i = 1; i < 3; i++) begin
        hd_v[i] <= hd_v[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        vd_v[i] <= vd_v[i-1];
      end
      v6_v <= vd_v[3];
      ve_v[0] <= v6_v;
      for (int i = 1; i < 3; i++) begin
        ve_v[i] <= ve_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_col <= hcol_e;
      h1_bank <= hbank_e;
      h1_mask <= h_mask_c;
      v1_col <= vcol_e;
      v1_bank <= vbank_e;
      v1_mask <= v_mask_c;
      v1_end <= v_lastcol && v_lastrow;
      hd_col[0] <= h1_col;
      hd_bank[0] <= h1_bank;
      for (int i = 1; i < 3; i++) begin
        hd_col[i] <= hd_col[i-1];
        hd_bank[i] <= hd_bank[i-1];
      end
      vd_col[0] <= v1_col;
      vd_bank[0] <= v1_bank;
      vd_mask[0] <= v1_mask;
      vd_end[0] <= v1_end;
      for (int i = 1; i < 3; i++) begin
        vd_col[i] <= vd_col[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        vd_bank[i] <= vd_bank[i-1];
        vd_mask[i] <= vd_mask[i-1];
        vd_end[i] <= vd_end[i-1];
      end
      vtaps <= rot;
      v6_mask <= vd_mask[3];
      v6_end <= vd_end[3];
      ve_end[0] <= v6_end;
      for (int i = 1; i < 3; i++) begin
        ve_end[i] <= ve_end[i-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      htaps[k] = win[TAPS-1-k];
    end
  end

  sgb_filter u_hfilter (
    .clk    (clk),
    .en     (en),
    .taps   (htaps),
    .mask   (h1_mask),
    .result (hres)
  );

  sgb_row_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .en    (en),
    .we    (hd_v[2]),
    .wbank (hd_bank[2]),
    .waddr (hd_col[2]),
    .wdata (hres),
    .raddr (vd_col[2]),
    .rdata (rdata)
  );

  always_comb begin
    logic [BANK_W:0] idx;
    for (int k = 0; k < TAPS; k++) begin
      idx = (BANK_W+1)'(vd_bank[3]) + (BANK_W+1)'((k + TAPS - HALF) % TAPS);
      if (idx >= (BANK_W+1)'(TAPS)) begin
        idx = idx - (BANK_W+1)'(TAPS);
      end
      rot[k] = rdata[idx[BANK_W-1:0]];
    end
  end

  sgb_filter u_vfilter (
    .clk    (clk),
    .en     (en),
    .taps   (vtaps),
    .mask   (v6_mask),
    .result (pixel_out)
  );

  assign out_valid = ve_v[2];
  assign frame_end = ve_end[2];

endmodule

[design/sgb_checker.sv]
// Port-level checker for the blur core and its bind to the top level.
`include "separable_gaussian_blur_argb_core_assert.svh"

module sgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out,
  input logic        frame_end
);

  `SGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_end))
  `SGB_ASSERT_IMPLY(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `SGB_ASSERT_IMPLY(a_free_when_empty, !out_valid, in_ready)
  `SGB_ASSERT_IMPLY(a_cfg_ready, cfg_valid, cfg_ready)
  `SGB_ASSERT_IMPLY(a_empty_after_reset, $past(rst), !out_valid)

endmodule

bind separable_gaussian_blur_argb_core sgb_checker u_sgb_checker (.*);
